>>> hw/rtl/rlp_pkg.sv
package rlp_pkg;

   // number of radix forms tracked side by side
   localparam int NUM_RADIX = 4;

   // classified character queue depth between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // radix codes, also the bit index of each radix lane
   typedef enum logic [1:0] {
      RADIX_HEX = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_BIN = 2'd2,
      RADIX_DEC = 2'd3
   } radix_type;

   // prefix seen after a leading zero
   typedef enum logic [2:0] {
      PFX_NONE = 3'd0,
      PFX_HEX  = 3'd1,
      PFX_OCT  = 3'd2,
      PFX_BIN  = 3'd3,
      PFX_DEC  = 3'd4
   } prefix_type;

   // character position, saturating at the third
   typedef enum logic [1:0] {
      POS_FIRST  = 2'd0,
      POS_SECOND = 2'd1,
      POS_REST   = 2'd2
   } pos_type;

   // ASCII marks
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_O     = 8'h6F;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_H     = 8'h68;

   // suffix mark per radix lane
   localparam logic [7:0] SFX_CHAR [NUM_RADIX] = '{CH_H, CH_O, CH_B, CH_D};

   // classified character, front to back
   typedef struct packed {
      logic                 last;
      logic [3:0]           dval;
      logic [NUM_RADIX-1:0] consume;
      logic [NUM_RADIX-1:0] dig_ok;
      logic [NUM_RADIX-1:0] form;
   } cls_type;

endpackage

>>> hw/rtl/rlp_front.sv
module rlp_front
   import rlp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tlast,   // last_char
   output logic       cls_valid,
   input  logic       cls_ready,
   output cls_type    cls_data
);

   pos_type    pos_ff, pos_in;
   logic       fz_ff, fz_in;
   prefix_type pk_ff, pk_in;

   logic                 is_dec;
   logic                 is_af;
   logic                 prefix_now;
   logic [NUM_RADIX-1:0] has_pfx;
   logic [NUM_RADIX-1:0] sfx;
   logic                 accept;

   assign req_tready = cls_ready;
   assign cls_valid  = req_tvalid;
   assign accept     = req_tvalid && cls_ready;

   // prefix and leading zero tracking
   always_comb begin
      pk_in      = pk_ff;
      prefix_now = 1'b0;
      if ((pos_ff == POS_SECOND) && fz_ff) begin
         prefix_now = 1'b1;
         priority if (req_tdata == CH_X) begin
            pk_in = PFX_HEX;
         end else if (req_tdata == CH_O) begin
            pk_in = PFX_OCT;
         end else if (req_tdata == CH_B) begin
            pk_in = PFX_BIN;
         end else if (req_tdata == CH_D) begin
            pk_in = PFX_DEC;
         end else begin
            prefix_now = 1'b0;
         end
      end
      fz_in = (pos_ff == POS_FIRST) ? (req_tdata == CH_ZERO) : fz_ff;
      pos_in = (pos_ff == POS_FIRST) ? POS_SECOND : POS_REST;
   end

   // character class, digit value and per-lane form and consume decision
   always_comb begin
      is_dec = (req_tdata >= CH_ZERO) && (req_tdata <= CH_NINE);
      is_af  = (req_tdata >= CH_A) && (req_tdata <= CH_F);
      cls_data.dval = is_dec ? req_tdata[3:0] : 4'(req_tdata[3:0] + 4'd9);
      cls_data.dig_ok[RADIX_HEX] = is_dec || is_af;
      cls_data.dig_ok[RADIX_OCT] = is_dec && (req_tdata[3:0] <= 4'd7);
      cls_data.dig_ok[RADIX_BIN] = is_dec && (req_tdata[3:0] <= 4'd1);
      cls_data.dig_ok[RADIX_DEC] = is_dec;
      cls_data.last = req_tlast;
      has_pfx[RADIX_HEX] = (pk_in == PFX_HEX);
      has_pfx[RADIX_OCT] = (pk_in == PFX_OCT);
      has_pfx[RADIX_BIN] = (pk_in == PFX_BIN);
      has_pfx[RADIX_DEC] = (pk_in == PFX_DEC);
      for (int r = 0; r < NUM_RADIX; r++) begin
         sfx[r] = req_tlast && !has_pfx[r] && (req_tdata == SFX_CHAR[r]);
         cls_data.consume[r] = !(prefix_now && has_pfx[r]) && !sfx[r];
      end
      cls_data.form[RADIX_HEX] = has_pfx[RADIX_HEX] || sfx[RADIX_HEX];
      cls_data.form[RADIX_OCT] = has_pfx[RADIX_OCT] || sfx[RADIX_OCT] || fz_in;
      cls_data.form[RADIX_BIN] = has_pfx[RADIX_BIN] || sfx[RADIX_BIN];
      cls_data.form[RADIX_DEC] = 1'b1;
   end

   // literal state, cleared after the last character
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_FIRST;
         fz_ff  <= 1'b0;
         pk_ff  <= PFX_NONE;
      end else if (accept) begin
         if (req_tlast) begin
            pos_ff <= POS_FIRST;
            fz_ff  <= 1'b0;
            pk_ff  <= PFX_NONE;
         end else begin
            pos_ff <= pos_in;
            fz_ff  <= fz_in;
            pk_ff  <= pk_in;
         end
      end
   end

endmodule

>>> hw/rtl/rlp_queue.sv
module rlp_queue
   import rlp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  cls_type wr_data,
   output logic    rd_valid,
   input  logic    rd_ready,
   output cls_type rd_data
);

   cls_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   cnt_ff;
   logic                push;
   logic                pop;

   assign wr_ready = (cnt_ff != QCNT_W'(QDEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_ff + 1'b1);
         end
         if (push && !pop) begin
            cnt_ff <= QCNT_W'(cnt_ff + 1'b1);
         end else if (pop && !push) begin
            cnt_ff <= QCNT_W'(cnt_ff - 1'b1);
         end
      end
   end

endmodule

>>> hw/rtl/rlp_back.sv
module rlp_back
   import rlp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cls_valid,
   output logic        cls_ready,
   input  cls_type     cls_data,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // [63:0] value
   output logic [2:0]  rsp_tuser   // [1:0] radix_kind, [2] is_valid
);

   logic [63:0]          acc_ff [NUM_RADIX];
   logic [63:0]          acc_in [NUM_RADIX];
   logic [63:0]          stepped [NUM_RADIX];
   logic [NUM_RADIX-1:0] flags_ff, flags_in;
   logic [NUM_RADIX-1:0] match;
   logic [63:0]          dig;
   logic                 take;

   logic                 rsp_valid_ff;
   logic [63:0]          rsp_value_ff, rsp_value_in;
   radix_type            rsp_kind_ff, rsp_kind_in;
   logic                 rsp_ok_ff, rsp_ok_in;

   assign cls_ready  = !cls_data.last || !rsp_valid_ff || rsp_tready;
   assign take       = cls_valid && cls_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_ok_ff, rsp_kind_ff};

   // accumulator step: shifts and adds per radix
   always_comb begin
      dig = {60'd0, cls_data.dval};
      stepped[RADIX_HEX] = {acc_ff[RADIX_HEX][59:0], 4'd0} + dig;
      stepped[RADIX_OCT] = {acc_ff[RADIX_OCT][60:0], 3'd0} + dig;
      stepped[RADIX_BIN] = {acc_ff[RADIX_BIN][62:0], 1'b0} + dig;
      stepped[RADIX_DEC] = {acc_ff[RADIX_DEC][60:0], 3'd0}
                         + {acc_ff[RADIX_DEC][62:0], 1'b0} + dig;
      for (int r = 0; r < NUM_RADIX; r++) begin
         acc_in[r] = (cls_data.consume[r] && cls_data.dig_ok[r]) ? stepped[r] : acc_ff[r];
         flags_in[r] = flags_ff[r] && !(cls_data.consume[r] && !cls_data.dig_ok[r]);
         match[r] = cls_data.form[r] && flags_in[r];
      end
   end

   // first matching form wins, hex first
   always_comb begin
      rsp_value_in = '0;
      rsp_kind_in  = RADIX_HEX;
      rsp_ok_in    = 1'b1;
      priority if (match[RADIX_HEX]) begin
         rsp_value_in = acc_in[RADIX_HEX];
         rsp_kind_in  = RADIX_HEX;
      end else if (match[RADIX_OCT]) begin
         rsp_value_in = acc_in[RADIX_OCT];
         rsp_kind_in  = RADIX_OCT;
      end else if (match[RADIX_BIN]) begin
         rsp_value_in = acc_in[RADIX_BIN];
         rsp_kind_in  = RADIX_BIN;
      end else if (match[RADIX_DEC]) begin
         rsp_value_in = acc_in[RADIX_DEC];
         rsp_kind_in  = RADIX_DEC;
      end else begin
         rsp_ok_in = 1'b0;
      end
   end

   // accumulators and digit flags, cleared after each literal
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_RADIX; r++) begin
            acc_ff[r] <= '0;
         end
         flags_ff <= '1;
      end else if (take) begin
         if (cls_data.last) begin
            for (int r = 0; r < NUM_RADIX; r++) begin
               acc_ff[r] <= '0;
            end
            flags_ff <= '1;
         end else begin
            for (int r = 0; r < NUM_RADIX; r++) begin
               acc_ff[r] <= acc_in[r];
            end
            flags_ff <= flags_in;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && cls_data.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && cls_data.last) begin
         rsp_value_ff <= rsp_value_in;
         rsp_kind_ff  <= rsp_kind_in;
         rsp_ok_ff    <= rsp_ok_in;
      end
   end

endmodule

>>> hw/rtl/radix_literal_parser_unit.sv
// Channel | Dir | Ports                | Item
// req     | in  | tvalid tready tdata  | char_in in tdata[7:0], last_char on tlast
//         |     | tlast                |
// rsp     | out | tvalid tready tdata  | value in tdata[63:0], radix_kind in tuser[1:0],
//         |     | tuser                | is_valid in tuser[2]
//
// One character per cycle while req_tready is high; rsp_tvalid rises once the last character has
// passed through the queue and the back end's 64-bit shift-and-add step into the output register.
// Synchronous active-high reset clears the literal state, queue and output register.
// A stalled result holds the back end only on a last character; that character waits
// in the two-entry queue, so the front takes one more character before req_tready drops.
module radix_literal_parser_unit
   import rlp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] value
   output logic [2:0]  rsp_tuser    // [1:0] radix_kind, [2] is_valid
);

   logic    f_valid, f_ready;
   cls_type f_data;
   logic    q_valid, q_ready;
   cls_type q_data;

   rlp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cls_valid  (f_valid),
      .cls_ready  (f_ready),
      .cls_data   (f_data)
   );

   rlp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_data  (f_data),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_data)
   );

   rlp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cls_valid  (q_valid),
      .cls_ready  (q_ready),
      .cls_data   (q_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import rlp_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int STREAM_ITEMS = 700;
   localparam int DRAIN_AT = 350;
   localparam int SETTLE_CYCLES = 20;
   localparam logic [7:0] PFX_MARK [NUM_RADIX] = '{CH_X, CH_O, CH_B, CH_D};

   // one character as the source presents it
   typedef struct {
      logic [7:0] ch;
      logic       last;
      bit         drain;
   } char_item_t;

   // one parsed literal as it leaves the block
   typedef struct packed {
      logic [63:0] value;
      radix_type   kind;
      logic        ok;
   } literal_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] char_in
   logic        req_tlast = 1'b0;    // last_char
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // [63:0] value
   logic [2:0]  rsp_tuser;           // [1:0] radix_kind, [2] is_valid

   char_item_t      char_stream [$];
   literal_result_t parsed_literals [$];
   int              mismatches = 0;
   int              cycles = 0;
   logic            calm = 1'b0;
   bit              mark_drain = 1'b0;

   // literal state of the predictor
   pos_type     lit_pos;
   logic        lit_lead_zero;
   prefix_type  lit_prefix;
   logic [63:0] lit_acc [NUM_RADIX];
   logic [3:0]  lit_digits_ok;

   radix_literal_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_literal();
      lit_pos = POS_FIRST;
      lit_lead_zero = 1'b0;
      lit_prefix = PFX_NONE;
      for (int i = 0; i < NUM_RADIX; i++) lit_acc[i] = '0;
      lit_digits_ok = 4'hF;
   endfunction

   // advance the literal by one character; returns 1 when a result is due
   function automatic bit parse_char(input logic [7:0] c, input logic last,
                                     output literal_result_t res);
      prefix_type  pk;
      radix_type   r;
      logic        lead_zero, pfx_now, has_pfx, sfx, form, legal;
      logic [3:0]  dv;
      logic [3:0]  matched;
      logic [63:0] weight;
      res = '0;
      pk = lit_prefix;
      pfx_now = 1'b0;
      // prefix mark right after a leading zero
      if (lit_pos == POS_SECOND && lit_lead_zero) begin
         for (int i = 0; i < NUM_RADIX; i++) begin
            if (c == PFX_MARK[i]) begin
               pk = prefix_type'(i + 1);
               pfx_now = 1'b1;
            end
         end
      end
      lead_zero = (lit_pos == POS_FIRST) ? (c == CH_ZERO) : lit_lead_zero;

      // all four lanes side by side
      for (int i = 0; i < NUM_RADIX; i++) begin
         r = radix_type'(i);
         has_pfx = (pk == prefix_type'(i + 1));
         sfx = last && !has_pfx && (c == SFX_CHAR[i]);
         if (!(pfx_now && has_pfx) && !sfx) begin
            legal = 1'b0;
            dv = '0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
               dv = 4'(c - CH_ZERO);
               legal = !(r == RADIX_OCT && dv > 4'd7) && !(r == RADIX_BIN && dv > 4'd1);
            end else if (r == RADIX_HEX && c >= CH_A && c <= CH_F) begin
               dv = 4'(c - CH_A + 8'd10);
               legal = 1'b1;
            end
            case (r)
               RADIX_HEX: weight = 64'd16;
               RADIX_OCT: weight = 64'd8;
               RADIX_BIN: weight = 64'd2;
               default:   weight = 64'd10;
            endcase
            if (legal) lit_acc[i] = lit_acc[i] * weight + 64'(dv);
            else lit_digits_ok[i] = 1'b0;
         end
         case (r)
            RADIX_OCT: form = has_pfx || sfx || lead_zero;
            RADIX_DEC: form = 1'b1;
            default:   form = has_pfx || sfx;
         endcase
         matched[i] = form && lit_digits_ok[i];
      end

      if (!last) begin
         lit_pos = (lit_pos == POS_FIRST) ? POS_SECOND : POS_REST;
         lit_lead_zero = lead_zero;
         lit_prefix = pk;
         return 1'b0;
      end
      // lowest radix code wins
      for (int i = NUM_RADIX - 1; i >= 0; i--) begin
         if (matched[i]) res = '{value: lit_acc[i], kind: radix_type'(i), ok: 1'b1};
      end
      clear_literal();
      return 1'b1;
   endfunction

   function automatic logic [7:0] rand_digit(radix_type r);
      int v;
      case (r)
         RADIX_HEX: begin
            v = $urandom_range(0, 15);
            return (v < 10) ? CH_ZERO + 8'(v) : CH_A + 8'(v - 10);
         end
         RADIX_OCT: return CH_ZERO + 8'($urandom_range(0, 7));
         RADIX_BIN: return CH_ZERO + 8'($urandom_range(0, 1));
         default:   return CH_ZERO + 8'($urandom_range(0, 9));
      endcase
   endfunction

   task automatic add_char(input logic [7:0] c, input logic last);
      char_stream.push_back('{ch: c, last: last, drain: mark_drain});
      mark_drain = 1'b0;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1);
   endtask

   // prefix, suffix or bare form with random digits, now and then one bad character
   task automatic add_random_literal();
      logic [7:0] text [$];
      radix_type  r;
      int         style, len;
      r = radix_type'($urandom_range(0, 3));
      style = $urandom_range(0, 2);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 8);
      if (style == 0) begin
         text.push_back(CH_ZERO);
         text.push_back(PFX_MARK[r]);
      end else if (style == 2 && r == RADIX_OCT) begin
         text.push_back(CH_ZERO);
      end
      for (int i = 0; i < len; i++) text.push_back(rand_digit(r));
      if (style == 1) text.push_back(SFX_CHAR[r]);
      if (text.size() == 0) text.push_back(rand_digit(r));
      if ($urandom_range(0, 9) == 0)
         text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      for (int i = 0; i < text.size(); i++) add_char(text[i], i == text.size() - 1);
   endtask

   task automatic flag_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      if (mismatches < 10)
         $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
      mismatches++;
   endtask

   // source side: present the head of the character stream
   always @(posedge clock) begin
      literal_result_t res;
      int src_gap;
      int sent;
      if (reset) begin
         req_tvalid <= 1'b0;
         src_gap = 0;
         sent = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (parse_char(req_tdata, req_tlast, res)) parsed_literals.push_back(res);
            void'(char_stream.pop_front());
            sent++;
         end
         if (req_tvalid && !req_tready) begin
            // item held until taken
         end else if (src_gap > 0) begin
            src_gap--;
            req_tvalid <= 1'b0;
         end else if (char_stream.size() == 0 ||
                      (char_stream[0].drain && parsed_literals.size() != 0)) begin
            req_tvalid <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            src_gap = $urandom_range(0, 8);
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= char_stream[0].ch;
            req_tlast <= char_stream[0].last;
         end
         calm <= (char_stream.size() < 120) || (sent % 200 >= 150);
      end
   end

   // result side: random stalls and field checks
   always @(posedge clock) begin
      literal_result_t want;
      int sink_gap;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (parsed_literals.size() == 0) begin
               flag_mismatch("result with none expected", '0, rsp_tdata);
            end else begin
               want = parsed_literals.pop_front();
               if (rsp_tdata !== want.value)
                  flag_mismatch("value", want.value, rsp_tdata);
               if (rsp_tuser[1:0] !== want.kind)
                  flag_mismatch("radix_kind", 64'(want.kind), 64'(rsp_tuser[1:0]));
               if (rsp_tuser[2] !== want.ok)
                  flag_mismatch("is_valid", 64'(want.ok), 64'(rsp_tuser[2]));
            end
         end
         if (sink_gap > 0) begin
            sink_gap--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            sink_gap = $urandom_range(0, 8);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int n;
      clear_literal();

      // directed: each radix form, bare marks, leading zero, case and byte extremes
      add_text("0xf9");
      add_text("7o");
      add_text("0");
      add_text("h");
      add_text("0o");
      add_text("101b");
      add_text("0d9");
      add_text("09");
      add_text("A");
      add_char(8'h00, 1'b1);
      add_char(8'hFF, 1'b1);

      // random: mostly well-formed literals, some raw noise
      while (char_stream.size() < STREAM_ITEMS) begin
         if (char_stream.size() >= DRAIN_AT && char_stream.size() < DRAIN_AT + 30)
            mark_drain = 1'b1;
         if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) add_char(8'($urandom_range(0, 255)), i == n - 1);
         end else begin
            add_random_literal();
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (char_stream.size() != 0 || parsed_literals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (parsed_literals.size() != 0)
         flag_mismatch("results never arrived", 64'(parsed_literals.size()), '0);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
